// ===== sv/edf_pkg.sv =====
// Package for the deadline-first task scheduler: payload types and event codes.
`timescale 1ns / 1ps
package edf_pkg;

  localparam int unsigned QueueDepthDefault = 16;

  typedef enum logic [2:0] {
    EV_ADMITTED  = 3'd0,
    EV_FULL      = 3'd1,
    EV_DROPPED   = 3'd2,
    EV_RAN       = 3'd3,
    EV_COMPLETED = 3'd4,
    EV_IDLE      = 3'd5,
    EV_HALTED    = 3'd6
  } event_e;

  localparam logic KIND_ADMIT = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] task_id;
    logic [31:0] deadline;
    logic [15:0] burst;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] event_task_id;
    logic [15:0] remaining;
    logic [31:0] turnaround;
    logic [31:0] wait_res;
    logic [31:0] tick;
    logic        last;
  } res_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;   // capture request
    logic scan_clr;   // start a head search
    logic scan_step;  // examine one slot
    logic do_admit;   // store request, emit admitted or full
    logic do_drop;    // emit dropped, free head
    logic do_run;     // run head one unit, emit ran/completed, tick++
    logic do_idle;    // emit idle, tick++
    logic do_halt;    // emit halted for head, set halt
    logic do_halted;  // emit bare halted
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic kind;
    logic halted;
    logic drop_mode;
    logic scan_done;
    logic head_found;
    logic head_late;
  } dp_sts_t;

endpackage

// ===== sv/edf_datapath.sv =====
// Datapath: task slots, counters, sequential head search and result register.
`timescale 1ns / 1ps
module edf_datapath #(
  parameter int unsigned QueueDepth = edf_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  edf_pkg::req_t    req_i,
  input  logic             drop_infeasible_i,
  input  edf_pkg::dp_cmd_t cmd_i,
  output edf_pkg::dp_sts_t sts_o,
  output logic             res_valid_o,
  output edf_pkg::res_t    res_o
);
  import edf_pkg::*;

  localparam int unsigned IdxW = $clog2(QueueDepth);

  req_t req_q;
  logic [QueueDepth-1:0] valid_q;
  logic [15:0] id_q    [QueueDepth];
  logic [31:0] dl_q    [QueueDepth];
  logic [15:0] rem_q   [QueueDepth];
  logic [15:0] tot_q   [QueueDepth];
  logic [31:0] arr_q   [QueueDepth];
  logic [31:0] ord_q   [QueueDepth];
  logic [31:0] admit_cnt_q, tick_q;
  logic        halted_q;

  // Head search: one slot per cycle.
  logic [IdxW:0]   scan_q;
  logic            found_q;
  logic [IdxW-1:0] best_q;
  logic [31:0]     best_dl_q, best_ord_q;

  logic            res_valid_q;
  res_t            res_q, res_d;

  logic [IdxW-1:0] si, free_idx;
  logic            better, any_free;
  logic [32:0]     slack;
  logic            late;
  logic [15:0]     new_rem;
  logic [31:0]     turn;

  assign si = scan_q[IdxW-1:0];
  assign better = valid_q[si] && (!found_q || dl_q[si] < best_dl_q ||
                  (dl_q[si] == best_dl_q && ord_q[si] < best_ord_q));

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        any_free = 1'b1;
      end
    end
  end

  // Signed slack compared to remaining burst.
  assign slack   = {1'b0, dl_q[best_q]} - {1'b0, tick_q};
  assign late    = slack[32] || (slack[31:0] < {16'd0, rem_q[best_q]});
  assign new_rem = (rem_q[best_q] != 16'd0) ? rem_q[best_q] - 16'd1 : 16'd0;
  assign turn    = tick_q - arr_q[best_q];

  assign sts_o.kind       = req_q.kind;
  assign sts_o.halted     = halted_q;
  assign sts_o.drop_mode  = drop_infeasible_i;
  assign sts_o.scan_done  = (scan_q == (IdxW+1)'(QueueDepth));
  assign sts_o.head_found = found_q;
  assign sts_o.head_late  = late;

  always_comb begin
    res_d      = '0;
    res_d.tick = tick_q;
    res_d.last = !cmd_i.do_drop;
    unique case (1'b1)
      cmd_i.do_admit: begin
        res_d.event_res     = any_free ? EV_ADMITTED : EV_FULL;
        res_d.event_task_id = req_q.task_id;
        res_d.remaining     = req_q.burst;
      end
      cmd_i.do_drop, cmd_i.do_halt: begin
        res_d.event_res     = cmd_i.do_drop ? EV_DROPPED : EV_HALTED;
        res_d.event_task_id = id_q[best_q];
        res_d.remaining     = rem_q[best_q];
      end
      cmd_i.do_run: begin
        res_d.event_task_id = id_q[best_q];
        if (new_rem == 16'd0) begin
          res_d.event_res  = EV_COMPLETED;
          res_d.turnaround = turn;
          res_d.wait_res   = (turn >= {16'd0, tot_q[best_q]}) ?
                             turn - {16'd0, tot_q[best_q]} : 32'd0;
        end else begin
          res_d.event_res = EV_RAN;
          res_d.remaining = new_rem;
        end
      end
      cmd_i.do_idle:   res_d.event_res = EV_IDLE;
      cmd_i.do_halted: res_d.event_res = EV_HALTED;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= req_i;
    end
    if (cmd_i.scan_step && better) begin
      best_q     <= si;
      best_dl_q  <= dl_q[si];
      best_ord_q <= ord_q[si];
    end
    if (cmd_i.do_admit && any_free) begin
      id_q[free_idx]  <= req_q.task_id;
      dl_q[free_idx]  <= req_q.deadline;
      rem_q[free_idx] <= req_q.burst;
      tot_q[free_idx] <= req_q.burst;
      arr_q[free_idx] <= tick_q;
      ord_q[free_idx] <= admit_cnt_q;
    end
    if (cmd_i.do_run) begin
      rem_q[best_q] <= new_rem;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      admit_cnt_q <= '0;
      tick_q      <= '0;
      halted_q    <= 1'b0;
      scan_q      <= '0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.do_admit | cmd_i.do_drop | cmd_i.do_run | cmd_i.do_idle |
                     cmd_i.do_halt | cmd_i.do_halted;
      if (cmd_i.scan_clr) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (better) found_q <= 1'b1;
      end
      if (cmd_i.do_admit && any_free) begin
        valid_q[free_idx] <= 1'b1;
        admit_cnt_q       <= admit_cnt_q + 32'd1;
      end
      if (cmd_i.do_drop) valid_q[best_q] <= 1'b0;
      if (cmd_i.do_run && new_rem == 16'd0) valid_q[best_q] <= 1'b0;
      if (cmd_i.do_run || cmd_i.do_idle) tick_q <= tick_q + 32'd1;
      if (cmd_i.do_halt) halted_q <= 1'b1;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  // A result is only produced in the cycle after a command that emits it.
  a_res_follows_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(cmd_i.do_admit | cmd_i.do_drop | cmd_i.do_run |
                          cmd_i.do_idle | cmd_i.do_halt | cmd_i.do_halted))
    else $error("result without command");
  // Once halted, the tick counter no longer moves.
  a_halt_freezes_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> $stable(tick_q))
    else $error("tick moved while halted");
  // Run, drop and halt act only on a valid head.
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.do_run || cmd_i.do_drop || cmd_i.do_halt) |-> valid_q[best_q])
    else $error("head slot not valid");
`endif
endmodule

// ===== sv/edf_ctrl.sv =====
// Controller state machine for the deadline-first task scheduler.
`timescale 1ns / 1ps
module edf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  edf_pkg::dp_sts_t sts_i,
  output logic             busy_o,
  output edf_pkg::dp_cmd_t cmd_o
);
  import edf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN, S_DECIDE, S_DRAIN
  } state_e;

  state_e state_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load_req = (state_q == S_IDLE) && start_i;
    unique case (state_q)
      S_IDLE: ;
      S_DISPATCH: begin
        if (sts_i.halted)               cmd_o.do_halted = 1'b1;
        else if (sts_i.kind == KIND_ADMIT) cmd_o.do_admit = 1'b1;
        else                            cmd_o.scan_clr  = 1'b1;
      end
      S_SCAN:   cmd_o.scan_step = !sts_i.scan_done;
      S_DECIDE: begin
        priority if (!sts_i.head_found) cmd_o.do_idle = 1'b1;
        else if (!sts_i.head_late)      cmd_o.do_run  = 1'b1;
        else if (!sts_i.drop_mode)      cmd_o.do_halt = 1'b1;
        else begin
          // Free the head and search again from slot zero.
          cmd_o.do_drop  = 1'b1;
          cmd_o.scan_clr = 1'b1;
        end
      end
      S_DRAIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:     if (start_i) state_q <= S_DISPATCH;
        S_DISPATCH: state_q <= (cmd_o.scan_clr) ? S_SCAN : S_DRAIN;
        S_SCAN:     if (sts_i.scan_done) state_q <= S_DECIDE;
        S_DECIDE:   state_q <= cmd_o.do_drop ? S_SCAN : S_DRAIN;
        S_DRAIN:    state_q <= S_IDLE;
        default:    state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef SYNTHESIS
  // Drop goes straight back to a fresh search.
  a_drop_rescans: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.do_drop |=> state_q == S_SCAN)
    else $error("drop not followed by scan");
  // At most one emitting command per cycle.
  a_one_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.do_admit, cmd_o.do_drop, cmd_o.do_run, cmd_o.do_idle,
              cmd_o.do_halt, cmd_o.do_halted}))
    else $error("multiple emits");
  // A request is only loaded while not busy.
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_req |-> !busy_o)
    else $error("load while busy");
`endif
endmodule

// ===== sv/deadline_first_task_scheduler_unit.sv =====
// Top level of the deadline-first task scheduler.
//
//  channel  | handshake              | payload
//  request  | start_i / busy_o       | req_i (edf_pkg::req_t)
//  result   | res_valid_o (strobe)   | res_o (edf_pkg::res_t)
//  config   | cfg_valid_i/cfg_ready_o| cfg_data_i (drop_infeasible)
//
// Admit or halted request: passes through dispatch, drain and idle.
// Tick: dispatch, then a head search over all QUEUE_DEPTH slots, one slot per
// cycle, then decide, drain and idle; each dropped head adds another search and decide.
// Reset clears all slot valid bits and counters at once; no clearing pass.
// Results are single-cycle strobes; the receiver cannot stall them.
`timescale 1ns / 1ps
module deadline_first_task_scheduler_unit #(
  parameter int unsigned QUEUE_DEPTH = edf_pkg::QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  edf_pkg::req_t req_i,
  output logic          res_valid_o,
  output edf_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);
  import edf_pkg::*;

  logic     drop_q;
  dp_cmd_t  cmd;
  dp_sts_t  sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      drop_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  edf_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .busy_o (busy),
    .cmd_o  (cmd)
  );

  edf_datapath #(.QueueDepth(QUEUE_DEPTH)) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req_i),
    .drop_infeasible_i(drop_q),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .res_valid_o      (res_valid_o),
    .res_o            (res_o)
  );
endmodule

// ===== sim/tb_top.sv =====
// Testbench for the deadline-first task scheduler: table-driven and random requests.
`timescale 1ns / 1ps
module tb_top;
  import edf_pkg::*;

  localparam int unsigned Depth = QueueDepthDefault;
  localparam int unsigned IdleLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic cfg_data_i;

  deadline_first_task_scheduler_unit #(.QUEUE_DEPTH(Depth)) u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Scheduler shadow state
  logic        sh_drop;
  logic        sh_valid [Depth];
  logic [15:0] sh_id    [Depth];
  logic [31:0] sh_dl    [Depth];
  logic [15:0] sh_rem   [Depth];
  logic [15:0] sh_tot   [Depth];
  logic [31:0] sh_arr   [Depth];
  logic [31:0] sh_ord   [Depth];
  logic [31:0] sh_admits;
  logic [31:0] sh_tick;
  logic        sh_halted;

  res_t events_due[$];
  int   mismatches;
  int   idle_cycles;

  function automatic res_t mk_event(event_e ev, logic [15:0] id, logic [15:0] rem,
                                    logic [31:0] turn, logic [31:0] wt);
    res_t r;
    r.event_res = ev;
    r.event_task_id = id;
    r.remaining = rem;
    r.turnaround = turn;
    r.wait_res = wt;
    r.tick = sh_tick;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic int earliest_slot();
    int best;
    best = -1;
    for (int i = 0; i < Depth; i++) begin
      if (!sh_valid[i]) continue;
      if (best < 0 || sh_dl[i] < sh_dl[best] ||
          (sh_dl[i] == sh_dl[best] && sh_ord[i] < sh_ord[best]))
        best = i;
    end
    return best;
  endfunction

  task automatic schedule_request(input req_t rq);
    res_t evs[$];
    int h;
    int slot;
    longint slack;
    logic [31:0] turn;
    if (sh_halted) begin
      evs.push_back(mk_event(EV_HALTED, '0, '0, '0, '0));
    end else if (rq.kind == KIND_ADMIT) begin
      slot = -1;
      for (int i = 0; i < Depth; i++)
        if (!sh_valid[i] && slot < 0) slot = i;
      if (slot < 0) begin
        evs.push_back(mk_event(EV_FULL, rq.task_id, rq.burst, '0, '0));
      end else begin
        sh_valid[slot] = 1'b1;
        sh_id[slot] = rq.task_id;
        sh_dl[slot] = rq.deadline;
        sh_rem[slot] = rq.burst;
        sh_tot[slot] = rq.burst;
        sh_arr[slot] = sh_tick;
        sh_ord[slot] = sh_admits;
        sh_admits++;
        evs.push_back(mk_event(EV_ADMITTED, rq.task_id, rq.burst, '0, '0));
      end
    end else begin
      forever begin
        h = earliest_slot();
        if (h < 0) begin
          evs.push_back(mk_event(EV_IDLE, '0, '0, '0, '0));
          sh_tick++;
          break;
        end
        slack = longint'(sh_dl[h]) - longint'(sh_tick);
        if (slack < longint'(sh_rem[h])) begin
          if (sh_drop) begin
            evs.push_back(mk_event(EV_DROPPED, sh_id[h], sh_rem[h], '0, '0));
            sh_valid[h] = 1'b0;
            continue;
          end
          sh_halted = 1'b1;
          evs.push_back(mk_event(EV_HALTED, sh_id[h], sh_rem[h], '0, '0));
          break;
        end
        if (sh_rem[h] != 0) sh_rem[h]--;
        if (sh_rem[h] == 0) begin
          turn = sh_tick - sh_arr[h];
          evs.push_back(mk_event(EV_COMPLETED, sh_id[h], '0, turn,
                                 turn >= sh_tot[h] ? turn - sh_tot[h] : '0));
          sh_valid[h] = 1'b0;
        end else begin
          evs.push_back(mk_event(EV_RAN, sh_id[h], sh_rem[h], '0, '0));
        end
        sh_tick++;
        break;
      end
    end
    evs[evs.size()-1].last = 1'b1;
    foreach (evs[k]) events_due.push_back(evs[k]);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (events_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        if (res_o !== events_due[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", events_due[0], res_o);
        end
        void'(events_due.pop_front());
      end
    end
  end

  // Watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Start stays high into the next request when no gap is drawn
  task automatic send_request(input req_t rq);
    int gap;
    gap = $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    schedule_request(rq);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (events_due.size() != 0) @(posedge clk_i);
    repeat (Depth * 20) @(posedge clk_i);
  endtask

  task automatic write_drop_mode(input logic val);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sh_drop = val;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t admit(logic [15:0] id, logic [31:0] dl, logic [15:0] bu);
    req_t r;
    r.kind = KIND_ADMIT;
    r.task_id = id;
    r.deadline = dl;
    r.burst = bu;
    return r;
  endfunction

  function automatic req_t tick_req();
    req_t r;
    r.kind = KIND_TICK;
    r.task_id = 16'($urandom());
    r.deadline = $urandom();
    r.burst = 16'($urandom());
    return r;
  endfunction

  // Directed rows; a typed expectation is checked against the predicted last result
  typedef struct {
    req_t   rq;
    logic   has_exp;
    event_e exp_ev;
  } row_t;

  row_t rows[$];
  req_t rq;

  initial begin
    start = 1'b0;
    req_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b1;
    rst_ni = 1'b0;
    mismatches = 0;
    idle_cycles = 0;
    sh_drop = 1'b1;
    sh_admits = '0;
    sh_tick = '0;
    sh_halted = 1'b0;
    foreach (sh_valid[i]) sh_valid[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{tick_req(), 1'b1, EV_IDLE});
    rows.push_back('{admit(16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF), 1'b1, EV_ADMITTED});
    rows.push_back('{admit(16'h0000, 32'd0, 16'd0), 1'b1, EV_ADMITTED});
    rows.push_back('{admit(16'h1234, 32'd3, 16'd1), 1'b1, EV_ADMITTED});
    rows.push_back('{admit(16'h0055, 32'd3, 16'd2), 1'b1, EV_ADMITTED});
    rows.push_back('{admit(16'h0777, 32'd1, 16'd5), 1'b1, EV_ADMITTED});
    rows.push_back('{tick_req(), 1'b0, EV_IDLE});
    rows.push_back('{tick_req(), 1'b0, EV_IDLE});
    rows.push_back('{tick_req(), 1'b0, EV_IDLE});
    rows.push_back('{tick_req(), 1'b0, EV_IDLE});
    foreach (rows[i]) begin
      send_request(rows[i].rq);
      if (rows[i].has_exp &&
          events_due[events_due.size()-1].event_res != rows[i].exp_ev) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d: expected event %0d, got %0d", i, rows[i].exp_ev,
                   events_due[events_due.size()-1].event_res);
      end
    end
    drain();
    // Fill queue to force the full case
    for (int i = 0; i < Depth + 2; i++)
      send_request(admit(16'($urandom()), 32'hFFFF_0000 + i, 16'($urandom_range(1, 3))));
    for (int i = 0; i < 8; i++) send_request(tick_req());
    drain();

    // Random: drop mode on, then off (halting), then on after halt.
    for (int ph = 0; ph < 3; ph++) begin
      write_drop_mode(ph == 1 ? 1'b0 : 1'b1);
      for (int n = 0; n < 25; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          send_request(tick_req());
        end else begin
          rq = admit(16'($urandom()),
                     $urandom_range(0, 3) == 0 ? $urandom() :
                       sh_tick + $urandom_range(0, 12),
                     $urandom_range(0, 7) == 0 ? 16'($urandom()) :
                       16'($urandom_range(0, 4)));
          send_request(rq);
        end
      end
      drain();
    end

    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
